### src/tlm_pkg.sv
// shared types and constants for the two-level logic minimizer
package tlm_pkg;

  localparam int unsigned NumVarsDef = 4;
  localparam int unsigned TermW = 4;
  localparam int unsigned MaskW = 16;
  localparam int unsigned QDepth = 2;

  // request passed from the front part to the cover engine
  typedef struct packed {
    logic [MaskW-1:0] on_set;
    logic [MaskW-1:0] care_set;
  } tlm_req_t;

endpackage

### src/tlm_front.sv
// input stage: masks the function, signals empty sets itself without queueing them, queues the rest
module tlm_front #(
  parameter int unsigned NUM_VARS = tlm_pkg::NumVarsDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [tlm_pkg::MaskW-1:0] in_on_set,
  input  logic [tlm_pkg::MaskW-1:0] in_dont_care_set,
  output logic                    q_valid,
  output tlm_pkg::tlm_req_t       q_data,
  input  logic                    q_pop,
  output logic                    empty_strobe,
  input  logic                    back_strobe,
  input  logic                    back_idle
);
  import tlm_pkg::*;

  localparam int unsigned NMint = 1 << NUM_VARS;
  localparam logic [MaskW-1:0] Univ = (NMint >= MaskW) ? {MaskW{1'b1}} :
                                       MaskW'((32'd1 << NMint) - 32'd1);

  tlm_req_t         q_mem_r [QDepth];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             empty_pend_r;
  logic [MaskW-1:0] dc, on;
  logic             acc, push;

  // drop bits above the last minterm; overlap counts as don't care
  assign dc   = in_dont_care_set & Univ;
  assign on   = in_on_set & Univ & ~dc;
  assign busy = (cnt_r == 2'(QDepth)) || empty_pend_r;
  assign acc  = start && !busy;
  assign push = acc && (on != '0);

  assign q_valid = (cnt_r != '0);
  assign q_data  = q_mem_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= '{on_set: on, care_set: on | dc};
    end
  end

  // queue pointers and empty result handling
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
      empty_pend_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
      if (acc && on == '0) empty_pend_r <= 1'b1;
      else if (empty_strobe) empty_pend_r <= 1'b0;
    end
  end

  // empty result waits until the queue is drained and the back part has finished
  assign empty_strobe = empty_pend_r && (cnt_r == '0) && back_idle && !back_strobe;

endmodule

### src/tlm_back.sv
// cover engine: essential pass and greedy cover rounds over the cube table
module tlm_back #(
  parameter int unsigned NUM_VARS = tlm_pkg::NumVarsDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  tlm_pkg::tlm_req_t       q_data,
  output logic                    q_pop,
  output logic                    idle,
  output logic                    out_strobe,
  output logic [tlm_pkg::TermW-1:0] out_value,
  output logic [tlm_pkg::TermW-1:0] out_care,
  output logic                    out_ess,
  output logic                    out_last
);
  import tlm_pkg::*;

  localparam int unsigned NCube = 81;
  localparam int unsigned CW = 7;
  localparam logic [TermW-1:0] VMask = TermW'((32'd1 << NUM_VARS) - 32'd1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ESS = 4'b0010,
    S_GREEDY = 4'b0100,
    S_EMIT = 4'b1000
  } st_t;

  st_t st_r;
  logic [MaskW-1:0] on_r, care_r, rem_r, cover_r;
  logic [CW-1:0] idx_r;
  logic [4:0] mint_r;
  logic [TermW-1:0] v_r, d_r;
  logic [4:0] bc_r;
  logic ess_r;
  logic [1:0] phase_r;
  logic [4:0] ecnt_r;

  // cube table: index = k-ordered enumeration of (value, dash)
  function automatic logic [2*TermW-1:0] cube_of(input logic [CW-1:0] i);
    int n;
    logic [2*TermW-1:0] r;
    n = 0;
    r = '0;
    for (int k = 0; k <= 4; k++)
      for (int v = 0; v < 16; v++)
        for (int d = 0; d < 16; d++)
          if ($countones(d[3:0]) == k && (v & d) == 0) begin
            if (n == int'(i)) r = {v[3:0], d[3:0]};
            n++;
          end
    return r;
  endfunction

  function automatic logic [MaskW-1:0] cset(input logic [TermW-1:0] v,
                                             input logic [TermW-1:0] d);
    logic [MaskW-1:0] s;
    s = '0;
    for (int m = 0; m < 16; m++)
      if ((m[3:0] & ~d) == v) s[m] = 1'b1;
    return s;
  endfunction

  logic [TermW-1:0] cv, cd;
  logic [MaskW-1:0] cs;
  logic in_range, is_prime;
  assign {cv, cd} = cube_of(idx_r);
  assign cs = cset(cv, cd);

  // a cube is prime when inside care and no single expansion stays inside
  always_comb begin
    in_range = ((cv | cd) & ~VMask) == '0;
    is_prime = in_range && ((cs & ~care_r) == '0);
    for (int b = 0; b < TermW; b++)
      if (VMask[b] && !cd[b] &&
          ((cset(cv & ~TermW'(1 << b), cd | TermW'(1 << b)) & ~care_r) == '0))
        is_prime = 1'b0;
  end

  logic [MaskW-1:0] pcov, rem_left;
  logic [4:0] pcnt;
  logic hit, ess_one, fin;
  assign pcov = cs & on_r;
  assign pcnt = 5'($countones(pcov & rem_r));

  // prime covers the minterm under test; exactly one such prime over the scan
  assign hit = is_prime && pcov[mint_r[3:0]];
  assign ess_one = (phase_r == 2'd1 && !hit) || (phase_r == 2'd0 && hit);

  // cover left after the selected term, and the end of the cover
  assign rem_left = rem_r & ~cover_r;
  assign fin = (rem_left == '0) || (ecnt_r == 5'd15);

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign idle = (st_r == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (st_r == S_EMIT);
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            on_r <= q_data.on_set;
            care_r <= q_data.care_set;
            rem_r <= q_data.on_set;
            idx_r <= '0;
            mint_r <= '0;
            phase_r <= '0;
            ecnt_r <= '0;
            st_r <= S_ESS;
          end
        end
        // per uncovered on-minterm, scan primes counting hits
        S_ESS: begin
          if (mint_r[4]) begin
            idx_r <= '0;
            bc_r <= '0;
            st_r <= S_GREEDY;
          end else if (!rem_r[mint_r[3:0]]) begin
            mint_r <= mint_r + 1'b1;
          end else if (idx_r == CW'(NCube - 1)) begin
            idx_r <= '0;
            phase_r <= '0;
            mint_r <= mint_r + 1'b1;
            if (ess_one) begin
              if (hit) begin
                v_r <= cv; d_r <= cd; cover_r <= pcov;
              end
              ess_r <= 1'b1;
              st_r <= S_EMIT;
            end
          end else begin
            if (hit) begin
              if (phase_r != 2'd2) phase_r <= phase_r + 1'b1;
              v_r <= cv; d_r <= cd; cover_r <= pcov;
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        // greedy: pick first prime with largest new coverage
        S_GREEDY: begin
          if (is_prime && pcnt > bc_r) begin
            bc_r <= pcnt; v_r <= cv; d_r <= cd; cover_r <= pcov;
          end
          if (idx_r == CW'(NCube - 1)) begin
            ess_r <= 1'b0;
            if ((is_prime && pcnt > bc_r) || bc_r != '0) st_r <= S_EMIT;
            else st_r <= S_IDLE;
            idx_r <= '0;
          end else idx_r <= idx_r + 1'b1;
        end
        S_EMIT: begin
          out_value <= v_r & VMask;
          out_care <= ~d_r & VMask;
          out_ess <= ess_r;
          out_last <= fin;
          rem_r <= rem_left;
          ecnt_r <= ecnt_r + 1'b1;
          bc_r <= '0;
          if (fin) st_r <= S_IDLE;
          else st_r <= ess_r ? S_ESS : S_GREEDY;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

### src/two_level_logic_minimizer.sv
// top level of the two-level logic minimizer
// One function is taken per request (start high while busy is low) into a two-entry
// request queue, so start is taken while the cover engine works; busy is high only
// while the queue is full or an empty on-set result waits for earlier results to
// finish. The engine scans the 81 cubes, one per cycle, once for each on-minterm
// still uncovered when it is reached, then once per greedy term. Results appear one
// per out_strobe with out_last on the final term and cannot be stalled; an empty
// on-set gives a single result with out_empty_res and out_last high.
module two_level_logic_minimizer #(
  parameter int unsigned NUM_VARS = tlm_pkg::NumVarsDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [tlm_pkg::MaskW-1:0] in_on_set,
  input  logic [tlm_pkg::MaskW-1:0] in_dont_care_set,
  output logic                      out_strobe,
  output logic [tlm_pkg::TermW-1:0] out_term_value,
  output logic [tlm_pkg::TermW-1:0] out_term_care_mask,
  output logic                      out_essential,
  output logic                      out_empty_res,
  output logic                      out_last
);
  import tlm_pkg::*;

  logic q_valid, q_pop, idle, es, bs;
  tlm_req_t q_data;
  logic [TermW-1:0] bv, bc;
  logic be, bl;

  tlm_front #(.NUM_VARS(NUM_VARS)) u_front (
    .clk, .rst_n, .start, .busy, .in_on_set, .in_dont_care_set,
    .q_valid, .q_data, .q_pop, .empty_strobe(es), .back_strobe(bs),
    .back_idle(idle)
  );

  tlm_back #(.NUM_VARS(NUM_VARS)) u_back (
    .clk, .rst_n, .q_valid(q_valid && !es), .q_data, .q_pop, .idle,
    .out_strobe(bs), .out_value(bv), .out_care(bc), .out_ess(be), .out_last(bl)
  );

  // merge the two result sources
  assign out_strobe         = bs || es;
  assign out_term_value     = bs ? bv : '0;
  assign out_term_care_mask = bs ? bc : '0;
  assign out_essential      = bs && be;
  assign out_empty_res      = es;
  assign out_last           = bs ? bl : es;

endmodule
